>>> rtl/core/plit_pkg.sv
package plit_pkg;

  // table geometry
  localparam int DEPTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 6;                  // entry_count register width

  // field widths
  localparam int RPM_W  = 20;
  localparam int FREQ_W = 31;
  localparam int OUT_W  = 32;
  localparam int RAM_W  = RPM_W + FREQ_W;

  // arithmetic widths
  localparam int MCAND_W = FREQ_W + 1;        // signed frequency difference
  localparam int MUL_BITS = RPM_W;            // magnitude of an rpm difference
  localparam int MCNT_W  = $clog2(MUL_BITS + 1);
  localparam int ACC_W   = MCAND_W + MUL_BITS + 1;
  localparam int DEN_W   = RPM_W;
  localparam int QBITS   = OUT_W + 1;
  localparam int QCNT_W  = $clog2(QBITS + 1);
  localparam int DIVH_W  = ACC_W - 1 - QBITS;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_FEW = 2'd1,
    ST_EQ  = 2'd2,
    ST_SAT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_LD0,
    S_LD1,
    S_LD2,
    S_PREP,
    S_MULA,
    S_MULB,
    S_ABS,
    S_DIV
  } state_t;

  typedef struct packed {
    logic load;
    logic clr;
  } mac_cmd_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_res_t;

endpackage

>>> rtl/core/plit_ram.sv
module plit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/plit_mac.sv
// Shift-add multiply-accumulate, one multiplier bit per cycle.
module plit_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  plit_pkg::mac_cmd_t                  cmd,
  input  logic signed [plit_pkg::MCAND_W-1:0] mcand,
  input  logic [plit_pkg::MUL_BITS-1:0]       mplier,
  output logic                                done,
  output logic signed [plit_pkg::ACC_W-1:0]   acc
);

  logic signed [plit_pkg::ACC_W-1:0] mc;
  logic [plit_pkg::MUL_BITS-1:0]     mp;
  logic [plit_pkg::MCNT_W-1:0]       cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (cmd.load) begin
      cnt  <= plit_pkg::MCNT_W'(plit_pkg::MUL_BITS);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - plit_pkg::MCNT_W'(1);
      done <= (cnt == plit_pkg::MCNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mc <= {{(plit_pkg::ACC_W - plit_pkg::MCAND_W){mcand[plit_pkg::MCAND_W-1]}}, mcand};
      mp <= mplier;
      if (cmd.clr) begin
        acc <= '0;
      end
    end else if (cnt != '0) begin
      if (mp[0]) begin
        acc <= acc + mc;
      end
      mc <= mc <<< 1;
      mp <= mp >> 1;
    end
  end

endmodule

>>> rtl/core/plit_div.sv
// Restoring divider, one quotient bit per cycle. Flags quotients of
// more than QBITS bits without iterating.
module plit_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [plit_pkg::ACC_W-2:0]    dividend,
  input  logic [plit_pkg::DEN_W-1:0]    divisor,
  output plit_pkg::div_res_t            res,
  output logic [plit_pkg::QBITS-1:0]    quo
);

  logic [plit_pkg::DEN_W-1:0]  rem;
  logic [plit_pkg::DEN_W-1:0]  dv;
  logic [plit_pkg::QCNT_W-1:0] cnt;
  logic [plit_pkg::DIVH_W-1:0] hi;
  logic                        ovf_now;
  logic [plit_pkg::DEN_W:0]    trial;
  logic [plit_pkg::DEN_W:0]    diff;
  logic                        ge;
  logic                        done;
  logic                        ovf;

  assign hi      = dividend[plit_pkg::ACC_W-2:plit_pkg::QBITS];
  assign ovf_now = plit_pkg::DEN_W'(hi) >= divisor;
  assign trial   = {rem, quo[plit_pkg::QBITS-1]};
  assign diff    = trial - {1'b0, dv};
  assign ge      = trial >= {1'b0, dv};
  assign res     = '{done: done, ovf: ovf};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (load) begin
      cnt  <= ovf_now ? '0 : plit_pkg::QCNT_W'(plit_pkg::QBITS);
      done <= ovf_now;
    end else if (cnt != '0) begin
      cnt  <= cnt - plit_pkg::QCNT_W'(1);
      done <= (cnt == plit_pkg::QCNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ovf <= ovf_now;
      dv  <= divisor;
      rem <= plit_pkg::DEN_W'(hi);
      quo <= dividend[plit_pkg::QBITS-1:0];
    end else if (cnt != '0) begin
      rem <= ge ? diff[plit_pkg::DEN_W-1:0] : trial[plit_pkg::DEN_W-1:0];
      quo <= {quo[plit_pkg::QBITS-2:0], ge};
    end
  end

endmodule

>>> rtl/core/piecewise_linear_interpolator.sv
// Piecewise-linear table interpolator. A command word (start high while
// busy is low) either writes one breakpoint {entry_rpm, entry_freq} at
// entry_index or queries the frequency for desired_rpm. Every command
// yields exactly one result word, shown on freq_out/status/segment for a
// single cycle with done high; there is no back-pressure, so the receiver
// must take it then. Writes and queries with fewer than two entries
// answer in the cycle after acceptance. A full query runs a linear
// search through the breakpoint RAM at one entry per cycle, stopping
// early when the search hits, then two RAM reads for the segment end
// points, two 20-step shift-add multiplies into one accumulator and a
// 33-step restoring divide, one bit per cycle each (the divide is
// skipped when the quotient is known to clamp). busy is high for the
// whole query. entry_count is to be written through entry_count_we
// only while no query is in flight; the block itself does not enforce
// this. Values above 32 are treated as 32. Table entries read before
// being written give meaningless results.
module piecewise_linear_interpolator (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                cmd,
  input  logic [4:0]          entry_index,
  input  logic signed [19:0]  entry_rpm,
  input  logic [30:0]         entry_freq,
  input  logic signed [19:0]  desired_rpm,
  input  logic                entry_count_we,
  input  logic [5:0]          entry_count,
  output logic                done,
  output logic signed [31:0]  freq_out,
  output logic [1:0]          status,
  output logic [4:0]          segment
);

  plit_pkg::state_t state, state_next;

  // config
  logic [plit_pkg::CNT_W-1:0]  ecount;
  logic [plit_pkg::CNT_W-1:0]  cnt_sat;
  logic [plit_pkg::ADDR_W-1:0] lim;

  // search
  logic                        accept;
  logic signed [plit_pkg::RPM_W-1:0] des;
  logic [plit_pkg::ADDR_W-1:0] a;
  logic [plit_pkg::ADDR_W-1:0] p;
  logic                        pv;
  logic [plit_pkg::ADDR_W-1:0] seg;
  logic                        hit;
  logic                        scan_end;
  logic [plit_pkg::ADDR_W-1:0] seg_found;

  // table RAM
  logic                        ram_we;
  logic [plit_pkg::ADDR_W-1:0] rd_addr;
  logic [plit_pkg::RAM_W-1:0]  rdata;
  logic signed [plit_pkg::RPM_W-1:0] rd_rpm;
  logic [plit_pkg::FREQ_W-1:0] rd_freq;

  // segment end points
  logic signed [plit_pkg::RPM_W-1:0] r0, r1;
  logic [plit_pkg::FREQ_W-1:0] f0, f1;

  // prep
  logic signed [plit_pkg::RPM_W:0]   den;
  logic signed [plit_pkg::RPM_W:0]   den_abs;
  logic signed [plit_pkg::RPM_W:0]   u;
  logic signed [plit_pkg::RPM_W:0]   u_abs;
  logic signed [plit_pkg::MCAND_W-1:0] df;
  logic signed [plit_pkg::MCAND_W-1:0] mcand_b_next;
  logic signed [plit_pkg::MCAND_W-1:0] mcand_b;
  logic [plit_pkg::DEN_W-1:0]    den_mag;
  logic [plit_pkg::MUL_BITS-1:0] u_mag;

  // mac / divider
  plit_pkg::mac_cmd_t                  mac_cmd;
  logic signed [plit_pkg::MCAND_W-1:0] mac_mcand;
  logic [plit_pkg::MUL_BITS-1:0]       mac_mplier;
  logic                                mac_done;
  logic signed [plit_pkg::ACC_W-1:0]   acc;
  logic signed [plit_pkg::ACC_W-1:0]   acc_abs;
  logic                                div_load;
  plit_pkg::div_res_t                  div_res;
  logic [plit_pkg::QBITS-1:0]          quo;
  logic                                nneg;
  logic                                sat_pos, sat_neg;

  // result
  logic                        finish;
  logic signed [plit_pkg::OUT_W-1:0] res_freq;
  plit_pkg::status_t           res_status;
  logic [plit_pkg::ADDR_W-1:0] res_seg;

  assign busy    = (state != plit_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign cnt_sat = (ecount > plit_pkg::CNT_W'(plit_pkg::DEPTH))
                   ? plit_pkg::CNT_W'(plit_pkg::DEPTH) : ecount;
  assign lim     = plit_pkg::ADDR_W'(cnt_sat - plit_pkg::CNT_W'(1));

  assign ram_we = accept && (cmd == plit_pkg::CMD_WRITE)
                  && (32'(entry_index) < plit_pkg::DEPTH);

  assign rd_rpm  = rdata[plit_pkg::FREQ_W +: plit_pkg::RPM_W];
  assign rd_freq = rdata[plit_pkg::FREQ_W-1:0];

  // Entry p is compared in the cycle after its address went out.
  assign hit       = pv && (rd_rpm >= des);
  assign scan_end  = hit || (pv && (p == lim - plit_pkg::ADDR_W'(1)));
  assign seg_found = hit ? ((p == '0) ? plit_pkg::ADDR_W'(1) : p) : lim;

  // Sign of the denominator is folded into the second product so the
  // divisor is always positive.
  assign den     = r1 - r0;
  assign den_abs = den[plit_pkg::RPM_W] ? -den : den;
  assign u       = des - r0;
  assign u_abs   = u[plit_pkg::RPM_W] ? -u : u;
  assign df      = $signed({1'b0, f1}) - $signed({1'b0, f0});
  assign mcand_b_next = (u[plit_pkg::RPM_W] ^ den[plit_pkg::RPM_W]) ? -df : df;

  assign acc_abs = acc[plit_pkg::ACC_W-1] ? -acc : acc;

  assign sat_pos = div_res.ovf || quo[plit_pkg::QBITS-1] || quo[plit_pkg::QBITS-2];
  assign sat_neg = div_res.ovf || quo[plit_pkg::QBITS-1]
                   || (quo[plit_pkg::QBITS-2] && (|quo[plit_pkg::QBITS-3:0]));

  plit_ram #(
    .WIDTH (plit_pkg::RAM_W),
    .DEPTH (plit_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_index[plit_pkg::ADDR_W-1:0]),
    .wdata ({entry_rpm, entry_freq}),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  plit_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .cmd    (mac_cmd),
    .mcand  (mac_mcand),
    .mplier (mac_mplier),
    .done   (mac_done),
    .acc    (acc)
  );

  plit_div u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (div_load),
    .dividend (acc_abs[plit_pkg::ACC_W-2:0]),
    .divisor  (den_mag),
    .res      (div_res),
    .quo      (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plit_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = a;
    mac_cmd    = '0;
    mac_mcand  = mcand_b;
    mac_mplier = u_mag;
    div_load   = 1'b0;
    finish     = 1'b0;
    res_freq   = '0;
    res_status = plit_pkg::ST_OK;
    res_seg    = '0;
    unique case (state)
      plit_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd == plit_pkg::CMD_WRITE) begin
            finish = 1'b1;
          end else if (cnt_sat < plit_pkg::CNT_W'(2)) begin
            finish     = 1'b1;
            res_status = plit_pkg::ST_FEW;
          end else begin
            state_next = plit_pkg::S_SCAN;
          end
        end
      end
      plit_pkg::S_SCAN: begin
        if (scan_end) begin
          state_next = plit_pkg::S_LD0;
        end
      end
      plit_pkg::S_LD0: begin
        rd_addr    = seg - plit_pkg::ADDR_W'(1);
        state_next = plit_pkg::S_LD1;
      end
      plit_pkg::S_LD1: begin
        rd_addr    = seg;
        state_next = plit_pkg::S_LD2;
      end
      plit_pkg::S_LD2: begin
        state_next = plit_pkg::S_PREP;
      end
      plit_pkg::S_PREP: begin
        if (den == '0) begin
          finish     = 1'b1;
          res_status = plit_pkg::ST_EQ;
          state_next = plit_pkg::S_IDLE;
        end else begin
          // f0 * |den|
          mac_cmd.load = 1'b1;
          mac_cmd.clr  = 1'b1;
          mac_mcand    = $signed({1'b0, f0});
          mac_mplier   = den_abs[plit_pkg::MUL_BITS-1:0];
          state_next   = plit_pkg::S_MULA;
        end
      end
      plit_pkg::S_MULA: begin
        if (mac_done) begin
          // += (+/-)(f1 - f0) * |des - r0|
          mac_cmd.load = 1'b1;
          state_next   = plit_pkg::S_MULB;
        end
      end
      plit_pkg::S_MULB: begin
        if (mac_done) begin
          state_next = plit_pkg::S_ABS;
        end
      end
      plit_pkg::S_ABS: begin
        div_load   = 1'b1;
        state_next = plit_pkg::S_DIV;
      end
      plit_pkg::S_DIV: begin
        if (div_res.done) begin
          finish     = 1'b1;
          res_seg    = seg;
          state_next = plit_pkg::S_IDLE;
          if (!nneg) begin
            if (sat_pos) begin
              res_freq   = {1'b0, {(plit_pkg::OUT_W-1){1'b1}}};
              res_status = plit_pkg::ST_SAT;
            end else begin
              res_freq = quo[plit_pkg::OUT_W-1:0];
            end
          end else begin
            if (sat_neg) begin
              res_freq   = {1'b1, {(plit_pkg::OUT_W-1){1'b0}}};
              res_status = plit_pkg::ST_SAT;
            end else begin
              res_freq = -$signed(quo[plit_pkg::OUT_W-1:0]);
            end
          end
        end
      end
      default: begin
        state_next = plit_pkg::S_IDLE;
      end
    endcase
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      ecount <= '0;
    end else if (entry_count_we) begin
      ecount <= entry_count;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      plit_pkg::S_IDLE: begin
        if (accept) begin
          des <= desired_rpm;
          a   <= '0;
          pv  <= 1'b0;
        end
      end
      plit_pkg::S_SCAN: begin
        a  <= a + plit_pkg::ADDR_W'(1);
        p  <= a;
        pv <= 1'b1;
        if (scan_end) begin
          seg <= seg_found;
        end
      end
      plit_pkg::S_LD1: begin
        r0 <= rd_rpm;
        f0 <= rd_freq;
      end
      plit_pkg::S_LD2: begin
        r1 <= rd_rpm;
        f1 <= rd_freq;
      end
      plit_pkg::S_PREP: begin
        den_mag <= den_abs[plit_pkg::DEN_W-1:0];
        u_mag   <= u_abs[plit_pkg::MUL_BITS-1:0];
        mcand_b <= mcand_b_next;
      end
      plit_pkg::S_ABS: begin
        nneg <= acc[plit_pkg::ACC_W-1];
      end
      default: begin
      end
    endcase
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      freq_out <= res_freq;
      status   <= res_status;
      segment  <= res_seg;
    end
  end

endmodule

>>> rtl/core/plit_chk.sv
module plit_chk (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               cmd,
  input logic               done,
  input logic signed [31:0] freq_out,
  input logic [1:0]         status,
  input logic [4:0]         segment
);

  // a write answers in the next cycle with an all-zero word
  a_write_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == plit_pkg::CMD_WRITE))
    |=> (done && (freq_out == '0) && (status == plit_pkg::ST_OK) && (segment == '0)))
    else $error("write command did not return a zero word");

  // results only come out once the engine is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word while busy");

  // a result word without a segment (errors and writes) carries no frequency
  a_no_seg_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (segment == '0)) |-> (freq_out == '0))
    else $error("nonzero frequency without a segment");

  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    (done && (status == plit_pkg::ST_SAT))
    |-> ((freq_out == 32'sh7fffffff) || (freq_out == 32'sh80000000)))
    else $error("saturated status without a clamped value");

endmodule

bind piecewise_linear_interpolator plit_chk u_plit_chk (.*);
